// ===== hdl/blac_pkg.sv =====
// Shared types, codes and constants of the binned lag autocorrelation unit.
`default_nettype none
package blac_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned ValW   = 16;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned CorrW  = 24;
  localparam int unsigned SumW   = 56;
  localparam int unsigned FracW  = 16;
  localparam int unsigned DvdW   = SumW + FracW;
  localparam int unsigned DvsW   = SumW;
  localparam int unsigned DivCntW = $clog2(DvdW);

  // bin store depth, tied to the index and count port widths
  localparam int unsigned MaxBins = 1024;

  // error flag bit positions
  localparam int unsigned FlOrder = 0;
  localparam int unsigned FlSat   = 1;
  localparam int unsigned FlZero  = 2;
  localparam int unsigned FlMax   = 3;

  localparam logic signed [CorrW-1:0] CorrPosMax = {1'b0, {(CorrW-1){1'b1}}};
  localparam logic signed [CorrW-1:0] CorrNegMin = {1'b1, {(CorrW-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ORDER    = 3'd1,
    ST_SAT      = 3'd2,
    ST_ZERO     = 3'd3,
    ST_MAXLAG   = 3'd4,
    ST_NOTREADY = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LOAD_LAST,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [TimeW-1:0]        sample_time;
    logic signed [ValW-1:0]  sample_value;
    logic [IdxW-1:0]         bin_index;
  } cmd_t;

  function automatic status_e flag_status(input logic [3:0] flags);
    status_e s;
    if (flags[FlOrder]) s = ST_ORDER;
    else if (flags[FlZero]) s = ST_ZERO;
    else if (flags[FlMax]) s = ST_MAXLAG;
    else if (flags[FlSat]) s = ST_SAT;
    else s = ST_OK;
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/blac_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module blac_div import blac_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 done_o,
  output logic [DvdW-1:0]      quotient_o
);

  logic               run_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvsW-1:0]    rem_q;
  logic [DvdW-1:0]    quo_q;
  logic [DvsW-1:0]    dvs_q;
  logic               done_q;
  logic [DvsW:0]      rem_sh;
  logic               fits;

  assign rem_sh = {rem_q, quo_q[DvdW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DvdW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? DvsW'(rem_sh - {1'b0, dvs_q}) : DvsW'(rem_sh);
      quo_q <= {quo_q[DvdW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== hdl/blac_front.sv =====
// Command front end: classifies accepted items and queues them for the back end.
`default_nettype none
module blac_front import blac_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic                   mode_i,
  input  wire logic [TimeW-1:0]       sample_time_i,
  input  wire logic signed [ValW-1:0] sample_value_i,
  input  wire logic                   last_sample_i,
  input  wire logic [IdxW-1:0]        bin_index_i,
  output logic                        busy_o,
  output logic                        cmd_valid_o,
  output cmd_t                        cmd_o,
  input  wire logic                   cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.sample_time  = sample_time_i;
    cmd_in.sample_value = sample_value_i;
    cmd_in.bin_index    = bin_index_i;
    if (mode_i) cmd_in.op = OP_READ;
    else if (last_sample_i) cmd_in.op = OP_LOAD_LAST;
    else cmd_in.op = OP_LOAD;
  end

  assign push        = start_i && !busy_o;
  assign busy_o      = fill_q == 2'd2;
  assign cmd_valid_o = fill_q != 2'd0;
  assign cmd_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (cmd_pop_i) rd_q <= !rd_q;
      if (push && !cmd_pop_i) fill_q <= fill_q + 2'd1;
      else if (!push && cmd_pop_i) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cmd_in;
  end

endmodule
`default_nettype wire

// ===== hdl/blac_back.sv =====
// Back end: sample store, bin store, pair sweep and normalised reads.
`default_nettype none
module blac_back import blac_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire cmd_t                cmd_i,
  output logic                     cmd_pop_o,
  input  wire logic [TimeW-1:0]    bin_width_i,
  input  wire logic [TimeW-1:0]    max_lag_i,
  output logic                     done_o,
  output status_e                  status_o,
  output logic [CountW-1:0]        bin_count_o,
  output logic [TimeW-1:0]         lag_o,
  output logic signed [CorrW-1:0]  corr_value_o
);

  localparam int unsigned SCW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SAW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned BCW  = $clog2(MaxBins + 1);
  localparam int unsigned BAW  = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  localparam int unsigned BndW = BCW + TimeW;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_NBDIV, S_CLEAR, S_RD_I, S_LAT_I, S_RD_J, S_EVAL,
    S_ACC, S_MAXRD, S_MAXCMP, S_FIN, S_RD_BIN, S_NDIV
  } state_e;

  state_e state_q;

  // series state
  logic [SCW-1:0]          cnt_q;
  logic [TimeW-1:0]        smin_q, width_q, first_q, prev_q;
  logic [3:0]              flags_q;
  logic                    ready_q;
  logic [BCW-1:0]          bins_q;
  logic signed [SumW-1:0]  largest_q;

  // sweep state
  logic [SCW-1:0]          i_q, j_q;
  logic [BCW-1:0]          b_q, ptr_q;
  logic [BndW-1:0]         bound_q;
  logic [TimeW-1:0]        ti_q;
  logic signed [ValW-1:0]  vi_q;
  logic signed [31:0]      prod_q;
  logic [TimeW-1:0]        lag_calc_q;
  logic                    neg_q;

  // result registers
  logic                    done_q;
  status_e                 status_q;
  logic [TimeW-1:0]        lag_q;
  logic signed [CorrW-1:0] corr_q;

  // memories
  logic [TimeW-1:0]        time_mem [MAX_SAMPLES];
  logic signed [ValW-1:0]  val_mem  [MAX_SAMPLES];
  logic signed [SumW-1:0]  bin_mem  [MaxBins];
  logic [TimeW-1:0]        t_rd_q;
  logic signed [ValW-1:0]  v_rd_q;
  logic signed [SumW-1:0]  bin_rd_q;

  logic                    s_we, s_re, bin_we, bin_re;
  logic [SAW-1:0]          s_wa, s_ra;
  logic [BAW-1:0]          bin_wa, bin_ra;
  logic signed [SumW-1:0]  bin_wd;

  // divider
  logic                    div_start, div_done;
  logic [DvdW-1:0]         div_dvd, div_quo;
  logic [DvsW-1:0]         div_dvs;

  // load path
  logic [SCW-1:0]          ld_cnt, ld_cnt_n;
  logic [TimeW-1:0]        ld_smin, ld_smin_n;
  logic [3:0]              ld_flags, ld_flags_n;
  logic                    ld_store;
  logic                    read_ok;
  logic [TimeW-1:0]        w_sel, span, dt;
  logic [3:0]              setup_flags;
  logic                    setup_go;
  logic [TimeW:0]          nb_sum;
  logic [BCW-1:0]          nb_sel;
  logic                    nb_sat;
  logic                    pair_hit, pair_step, pair_stop;
  logic [SumW-1:0]         abs_s, abs_m;
  logic [CountW+TimeW-1:0] lag_full;
  logic [CorrW-1:0]        q_mag;

  assign ld_cnt   = ready_q ? '0 : cnt_q;
  assign ld_smin  = ready_q ? '1 : smin_q;
  assign ld_flags = ready_q ? '0 : flags_q;
  assign ld_store = ld_cnt < SCW'(MAX_SAMPLES);

  always_comb begin
    ld_cnt_n   = ld_cnt;
    ld_smin_n  = ld_smin;
    ld_flags_n = ld_flags;
    if (ld_store) begin
      ld_cnt_n = ld_cnt + 1'b1;
      if (ld_cnt != '0) begin
        if (cmd_i.sample_time < prev_q) ld_flags_n[FlOrder] = 1'b1;
        else if (cmd_i.sample_time - prev_q < ld_smin)
          ld_smin_n = cmd_i.sample_time - prev_q;
      end
    end
  end

  assign read_ok = ready_q && !flags_q[FlOrder] && !flags_q[FlZero] &&
                   (32'(cmd_i.bin_index) < 32'(bins_q));

  assign w_sel = (bin_width_i != '0) ? bin_width_i : smin_q;
  always_comb begin
    setup_flags = flags_q;
    if (max_lag_i == '0) setup_flags[FlMax] = 1'b1;
    if (w_sel == '0) setup_flags[FlZero] = 1'b1;
  end
  assign setup_go = !setup_flags[FlOrder] && !setup_flags[FlZero] && (cnt_q != '0);
  assign span     = prev_q - first_q;
  assign nb_sum   = {1'b0, span} + {1'b0, w_sel} - 1'b1;
  assign nb_sat   = div_quo > DvdW'(MaxBins);
  assign nb_sel   = nb_sat ? BCW'(MaxBins) : BCW'(div_quo);

  assign dt        = t_rd_q - ti_q;
  assign pair_step = (BndW'(dt) >= bound_q);
  assign pair_stop = (dt > max_lag_i) || (pair_step && (b_q + 1'b1 == bins_q));
  assign pair_hit  = !pair_stop && !pair_step;

  assign abs_s    = bin_rd_q[SumW-1] ? SumW'(-bin_rd_q) : SumW'(bin_rd_q);
  assign abs_m    = largest_q[SumW-1] ? SumW'(-largest_q) : SumW'(largest_q);
  assign lag_full = (CountW + TimeW)'((CountW'(cmd_i.bin_index) + 1'b1) * 43'(width_q));
  assign q_mag    = {1'b0, div_quo[CorrW-2:0]};

  // memory and divider controls
  always_comb begin
    cmd_pop_o = 1'b0;
    s_we      = 1'b0;
    s_wa      = ld_cnt[SAW-1:0];
    s_re      = 1'b0;
    s_ra      = i_q[SAW-1:0];
    bin_we    = 1'b0;
    bin_wa    = b_q[BAW-1:0];
    bin_wd    = '0;
    bin_re    = 1'b0;
    bin_ra    = b_q[BAW-1:0];
    div_start = 1'b0;
    div_dvd   = DvdW'(nb_sum);
    div_dvs   = DvsW'(w_sel);
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_READ) begin
            bin_re = read_ok;
            bin_ra = BAW'(cmd_i.bin_index);
          end else begin
            s_we = ld_store;
          end
        end
      end
      S_SETUP: div_start = setup_go;
      S_CLEAR: begin
        bin_we = 1'b1;
        bin_wa = ptr_q[BAW-1:0];
      end
      S_RD_I: s_re = i_q != cnt_q;
      S_RD_J: begin
        s_re = j_q != cnt_q;
        s_ra = j_q[SAW-1:0];
      end
      S_EVAL: bin_re = pair_hit;
      S_ACC: begin
        bin_we = 1'b1;
        bin_wd = bin_rd_q + SumW'(prod_q);
      end
      S_MAXRD: begin
        bin_re = 1'b1;
        bin_ra = ptr_q[BAW-1:0];
      end
      S_RD_BIN: begin
        div_start = (bin_rd_q != '0) && (largest_q != '0);
        div_dvd   = {abs_s, {FracW{1'b0}}};
        div_dvs   = abs_m;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      time_mem[s_wa] <= cmd_i.sample_time;
      val_mem[s_wa]  <= cmd_i.sample_value;
    end
    if (s_re) begin
      t_rd_q <= time_mem[s_ra];
      v_rd_q <= val_mem[s_ra];
    end
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    if (bin_re) bin_rd_q <= bin_mem[bin_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      smin_q     <= '1;
      width_q    <= '0;
      flags_q    <= '0;
      ready_q    <= 1'b0;
      bins_q     <= '0;
      largest_q  <= '0;
      i_q        <= '0;
      j_q        <= '0;
      b_q        <= '0;
      ptr_q      <= '0;
      done_q     <= 1'b0;
      status_q   <= ST_OK;
      lag_q      <= '0;
      corr_q     <= '0;
    end else begin
      done_q <= 1'b0;
      lag_q  <= '0;
      corr_q <= '0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.op == OP_READ) begin
              if (!ready_q) begin
                done_q   <= 1'b1;
                status_q <= ST_NOTREADY;
              end else if (flags_q[FlOrder] || flags_q[FlZero]) begin
                done_q   <= 1'b1;
                status_q <= flag_status(flags_q);
              end else if (!read_ok) begin
                done_q   <= 1'b1;
                status_q <= ST_NOTREADY;
              end else begin
                lag_calc_q <= (lag_full[CountW+TimeW-1:TimeW] != '0) ? '1
                                                                     : lag_full[TimeW-1:0];
                state_q    <= S_RD_BIN;
              end
            end else begin
              cnt_q   <= ld_cnt_n;
              smin_q  <= ld_smin_n;
              flags_q <= ld_flags_n;
              ready_q <= 1'b0;
              if (ld_store) begin
                prev_q <= cmd_i.sample_time;
                if (ld_cnt == '0) first_q <= cmd_i.sample_time;
              end
              if (cmd_i.op == OP_LOAD_LAST) begin
                state_q <= S_SETUP;
              end else begin
                done_q   <= 1'b1;
                status_q <= flag_status(ld_flags_n);
              end
            end
          end
        end
        S_SETUP: begin
          flags_q   <= setup_flags;
          width_q   <= w_sel;
          ready_q   <= 1'b1;
          bins_q    <= '0;
          largest_q <= '0;
          state_q   <= setup_go ? S_NBDIV : S_FIN;
        end
        S_NBDIV: begin
          if (div_done) begin
            bins_q <= nb_sel;
            if (nb_sat) flags_q[FlSat] <= 1'b1;
            ptr_q   <= '0;
            state_q <= (nb_sel == '0) ? S_FIN : S_CLEAR;
          end
        end
        S_CLEAR: begin
          // wipe only the bins in use
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q + 1'b1 == bins_q) begin
            i_q     <= '0;
            state_q <= S_RD_I;
          end
        end
        S_RD_I: begin
          if (i_q == cnt_q) begin
            ptr_q   <= '0;
            state_q <= S_MAXRD;
          end else begin
            state_q <= S_LAT_I;
          end
        end
        S_LAT_I: begin
          ti_q    <= t_rd_q;
          vi_q    <= v_rd_q;
          j_q     <= i_q + 1'b1;
          b_q     <= '0;
          bound_q <= BndW'(width_q);
          state_q <= S_RD_J;
        end
        S_RD_J: begin
          if (j_q == cnt_q) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_RD_I;
          end else begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (pair_stop) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_RD_I;
          end else if (pair_step) begin
            // advance the bin until the lag falls below its upper edge
            b_q     <= b_q + 1'b1;
            bound_q <= bound_q + BndW'(width_q);
          end else begin
            prod_q  <= 32'(vi_q) * 32'(v_rd_q);
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          j_q     <= j_q + 1'b1;
          state_q <= S_RD_J;
        end
        S_MAXRD: state_q <= S_MAXCMP;
        S_MAXCMP: begin
          if (ptr_q == '0 || bin_rd_q > largest_q) largest_q <= bin_rd_q;
          ptr_q <= ptr_q + 1'b1;
          state_q <= (ptr_q + 1'b1 == bins_q) ? S_FIN : S_MAXRD;
        end
        S_FIN: begin
          done_q   <= 1'b1;
          status_q <= flag_status(flags_q);
          state_q  <= S_IDLE;
        end
        S_RD_BIN: begin
          neg_q <= bin_rd_q[SumW-1] != largest_q[SumW-1];
          if (bin_rd_q == '0) begin
            done_q   <= 1'b1;
            status_q <= flag_status(flags_q);
            lag_q    <= lag_calc_q;
            state_q  <= S_IDLE;
          end else if (largest_q == '0) begin
            done_q   <= 1'b1;
            status_q <= flag_status(flags_q);
            lag_q    <= lag_calc_q;
            corr_q   <= bin_rd_q[SumW-1] ? CorrNegMin : CorrPosMax;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (div_done) begin
            done_q   <= 1'b1;
            status_q <= flag_status(flags_q);
            lag_q    <= lag_calc_q;
            if (div_quo[DvdW-1:CorrW-1] != '0) corr_q <= neg_q ? CorrNegMin : CorrPosMax;
            else corr_q <= neg_q ? -q_mag : q_mag;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  blac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign bin_count_o  = CountW'(bins_q);
  assign lag_o        = lag_q;
  assign corr_value_o = corr_q;

endmodule
`default_nettype wire

// ===== hdl/binned_lag_autocorrelation_unit.sv =====
// Top level of the binned lag autocorrelation unit.
//
// Command channel: an item is taken when start is high and busy low. mode_i 0
// loads one (time, value) sample; last_sample_i on a load starts the bin pass.
// mode_i 1 reads one bin. Every item yields exactly one result beat, shown for
// one cycle with done_o high; the receiver cannot stall it.
// A two-entry queue sits in front of the sequencer, so busy rises only when
// it is full. Items are carried out one at a time in order.
// Plain load: queued, then taken by the idle sequencer, which registers the
// result; one load per cycle sustained while the sequencer is idle.
// Last load: setup, a divide for the bin count, a clear of each bin in use,
// then the pair sweep through the single sample-memory port, then the
// largest-bin search.
// Read: a refused read answers from the idle state; otherwise the bin is read,
// and the normalising divide runs unless the bin or the largest bin is zero.
// Configuration: cfg_we_i writes bin width (index 0) or max lag (index 1) at
// once; write only while idle.
// Reset empties the queue, clears the series and sets max lag to 60.0.
`default_nettype none
module binned_lag_autocorrelation_unit import blac_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   mode_i,
  input  wire logic [TimeW-1:0]       sample_time_i,
  input  wire logic signed [ValW-1:0] sample_value_i,
  input  wire logic                   last_sample_i,
  input  wire logic [IdxW-1:0]        bin_index_i,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_index_i,
  input  wire logic [TimeW-1:0]       cfg_wdata_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [CountW-1:0]           bin_count_o,
  output logic [TimeW-1:0]            lag_o,
  output logic signed [CorrW-1:0]     corr_value_o
);

  localparam logic CfgBinWidth = 1'b0;
  localparam logic CfgMaxLag   = 1'b1;

  logic [TimeW-1:0] bin_width_q, max_lag_q;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  status_e          status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= '0;
      max_lag_q   <= 32'd3932160;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBinWidth: bin_width_q <= cfg_wdata_i;
        CfgMaxLag:   max_lag_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  blac_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .mode_i         (mode_i),
    .sample_time_i  (sample_time_i),
    .sample_value_i (sample_value_i),
    .last_sample_i  (last_sample_i),
    .bin_index_i    (bin_index_i),
    .busy_o         (busy),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  blac_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .bin_width_i  (bin_width_q),
    .max_lag_i    (max_lag_q),
    .done_o       (done_o),
    .status_o     (status),
    .bin_count_o  (bin_count_o),
    .lag_o        (lag_o),
    .corr_value_o (corr_value_o)
  );

  assign status_o = status;

  // a refused read carries no lag and no correlation
  a_notready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status == ST_NOTREADY |-> lag_o == '0 && corr_value_o == '0)
    else $error("refused beat carries payload");

  // payload is zero outside a result beat
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> lag_o == '0 && corr_value_o == '0)
    else $error("payload outside result beat");

  // a correlation only comes with a usable status
  a_corr_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corr_value_o != '0 |-> status == ST_OK || status == ST_SAT || status == ST_MAXLAG)
    else $error("correlation with error status");

endmodule
`default_nettype wire
